// ===== sv/lis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lis_pkg: shared types and constants for the line intersection snap block
// Widths, lane and point indexes, and the stage record passed between cells.
// ----------------------------------------------------------------------------
package lis_pkg;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 16;
	localparam int PARAM_W = 48;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int WIDE_W  = 2 * COORD_W + 2;
	localparam int MAG_W   = WIDE_W - 1;
	localparam int DVD_W   = MAG_W + ((DIFF_W > FRAC_W) ? DIFF_W : FRAC_W);
	localparam int REM_W   = MAG_W;
	localparam int CMP_W   = ((DVD_W > PARAM_W) ? DVD_W : PARAM_W) + 1;
	localparam int SUM_W   = DIFF_W + 2;
	localparam int LANES   = 4;
	localparam int NPTS    = 4;
	localparam int LATENCY = 4 + DVD_W + 2;

	// divider lanes
	localparam int LANE_U1 = 0;
	localparam int LANE_U2 = 1;
	localparam int LANE_X  = 2;
	localparam int LANE_Y  = 3;

	// endpoints
	localparam int PT_A = 0;
	localparam int PT_B = 1;
	localparam int PT_C = 2;
	localparam int PT_D = 3;

	typedef struct packed {
		logic [LANES-1:0][REM_W-1:0] rem;
		logic [LANES-1:0][DVD_W-1:0] dq;
		logic [MAG_W-1:0]            dvs;
	} div_t;

	typedef struct packed {
		logic [NPTS-1:0][COORD_W-1:0] xs;
		logic [NPTS-1:0][COORD_W-1:0] ys;
		logic [WIDE_W-1:0]            det;
		logic [WIDE_W-1:0]            n1;
		logic [WIDE_W-1:0]            n2;
		logic [LANES-1:0]             neg;
	} side_t;

endpackage
`default_nettype wire

// ===== sv/line_intersection_snap.sv =====
`default_nettype none
// stages: 4 front stages, 50 divider cells and 2 output stages from start to done;
//   the divider chain develops one quotient bit per cell
// throughput: one item per cycle, busy stays low
// reset: arst_n clears all valid bits at once; no result appears until a new start
// ----------------------------------------------------------------------------
// line_intersection_snap: intersection of two lines given by endpoints
// Determinant, numerators, Q.16 parameters and a clamped, snapped point.
// ----------------------------------------------------------------------------
module line_intersection_snap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [lis_pkg::COORD_W-1:0]  a_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  a_y,
	input  logic signed [lis_pkg::COORD_W-1:0]  b_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  b_y,
	input  logic signed [lis_pkg::COORD_W-1:0]  c_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  c_y,
	input  logic signed [lis_pkg::COORD_W-1:0]  d_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  d_y,
	output logic                                done,
	output logic signed [lis_pkg::COORD_W-1:0]  cross_x,
	output logic signed [lis_pkg::COORD_W-1:0]  cross_y,
	output logic signed [lis_pkg::WIDE_W-1:0]   det,
	output logic signed [lis_pkg::WIDE_W-1:0]   num_first,
	output logic signed [lis_pkg::WIDE_W-1:0]   num_second,
	output logic signed [lis_pkg::PARAM_W-1:0]  param_first,
	output logic signed [lis_pkg::PARAM_W-1:0]  param_second,
	output logic                                parallel,
	output logic                                clamped
);
	import lis_pkg::*;

	logic  valid_c [DVD_W+1];
	div_t  div_c   [DVD_W+1];
	side_t side_c  [DVD_W+1];

	assign busy = 1'b0;

	lis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.a_x       (a_x),
		.a_y       (a_y),
		.b_x       (b_x),
		.b_y       (b_y),
		.c_x       (c_x),
		.c_y       (c_y),
		.d_x       (d_x),
		.d_y       (d_y),
		.valid_out (valid_c[0]),
		.div_out   (div_c[0]),
		.side_out  (side_c[0])
	);

	for (genvar g = 0; g < DVD_W; g++) begin : g_cell
		lis_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_c[g]),
			.div_in    (div_c[g]),
			.side_in   (side_c[g]),
			.valid_out (valid_c[g+1]),
			.div_out   (div_c[g+1]),
			.side_out  (side_c[g+1])
		);
	end

	lis_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_c[DVD_W]),
		.div_in       (div_c[DVD_W]),
		.side_in      (side_c[DVD_W]),
		.done         (done),
		.cross_x      (cross_x),
		.cross_y      (cross_y),
		.det          (det),
		.num_first    (num_first),
		.num_second   (num_second),
		.param_first  (param_first),
		.param_second (param_second),
		.parallel     (parallel),
		.clamped      (clamped)
	);

endmodule
`default_nettype wire

// ===== sv/lis_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lis_front: determinant and numerators
// Four stages: differences, products, sums, magnitudes and dividend products.
// ----------------------------------------------------------------------------
module lis_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [lis_pkg::COORD_W-1:0]  a_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  a_y,
	input  logic signed [lis_pkg::COORD_W-1:0]  b_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  b_y,
	input  logic signed [lis_pkg::COORD_W-1:0]  c_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  c_y,
	input  logic signed [lis_pkg::COORD_W-1:0]  d_x,
	input  logic signed [lis_pkg::COORD_W-1:0]  d_y,
	output logic                                valid_out,
	output lis_pkg::div_t                       div_out,
	output lis_pkg::side_t                      side_out
);
	import lis_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic signed [DIFF_W-1:0] d12x_s1, d12y_s1, d34x_s1, d34y_s1, acx_s1, acy_s1;
	logic signed [DIFF_W-1:0] d12x_s2, d12y_s2, d12x_s3, d12y_s3;
	logic [NPTS-1:0][COORD_W-1:0] xs_s1, ys_s1, xs_s2, ys_s2, xs_s3, ys_s3;
	logic signed [WIDE_W-1:0] pk0_s2, pk1_s2, pa0_s2, pa1_s2, pb0_s2, pb1_s2;
	logic signed [WIDE_W-1:0] det_s3, n1_s3, n2_s3;
	logic [MAG_W-1:0] abs_det, abs_n1, abs_n2;
	logic [DIFF_W-1:0] abs_dx, abs_dy;
	logic [MAG_W+DIFF_W-1:0] prod_x, prod_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_out <= 1'b0;
		end else begin
			valid_s1  <= start;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_out <= valid_s3;
		end
	end

	always_comb begin
		abs_det = MAG_W'(det_s3[WIDE_W-1] ? -det_s3 : det_s3);
		abs_n1  = MAG_W'(n1_s3[WIDE_W-1] ? -n1_s3 : n1_s3);
		abs_n2  = MAG_W'(n2_s3[WIDE_W-1] ? -n2_s3 : n2_s3);
		abs_dx  = d12x_s3[DIFF_W-1] ? DIFF_W'(-d12x_s3) : DIFF_W'(d12x_s3);
		abs_dy  = d12y_s3[DIFF_W-1] ? DIFF_W'(-d12y_s3) : DIFF_W'(d12y_s3);
		prod_x  = abs_n1 * abs_dx;
		prod_y  = abs_n1 * abs_dy;
	end

	always_ff @(posedge clk) begin
		// stage 1: direction and offset vectors
		d12x_s1 <= DIFF_W'(b_x) - DIFF_W'(a_x);
		d12y_s1 <= DIFF_W'(b_y) - DIFF_W'(a_y);
		d34x_s1 <= DIFF_W'(d_x) - DIFF_W'(c_x);
		d34y_s1 <= DIFF_W'(d_y) - DIFF_W'(c_y);
		acx_s1  <= DIFF_W'(a_x) - DIFF_W'(c_x);
		acy_s1  <= DIFF_W'(a_y) - DIFF_W'(c_y);
		xs_s1   <= {d_x, c_x, b_x, a_x};
		ys_s1   <= {d_y, c_y, b_y, a_y};
		// stage 2: cross products
		pk0_s2  <= d34y_s1 * d12x_s1;
		pk1_s2  <= d34x_s1 * d12y_s1;
		pa0_s2  <= d34x_s1 * acy_s1;
		pa1_s2  <= d34y_s1 * acx_s1;
		pb0_s2  <= d12x_s1 * acy_s1;
		pb1_s2  <= d12y_s1 * acx_s1;
		d12x_s2 <= d12x_s1;
		d12y_s2 <= d12y_s1;
		xs_s2   <= xs_s1;
		ys_s2   <= ys_s1;
		// stage 3: determinant and numerators
		det_s3  <= pk0_s2 - pk1_s2;
		n1_s3   <= pa0_s2 - pa1_s2;
		n2_s3   <= pb0_s2 - pb1_s2;
		d12x_s3 <= d12x_s2;
		d12y_s3 <= d12y_s2;
		xs_s3   <= xs_s2;
		ys_s3   <= ys_s2;
		// stage 4: unsigned dividends for the divider chain
		div_out.rem              <= '0;
		div_out.dvs              <= abs_det;
		div_out.dq[LANE_U1]      <= DVD_W'({abs_n1, FRAC_W'(0)});
		div_out.dq[LANE_U2]      <= DVD_W'({abs_n2, FRAC_W'(0)});
		div_out.dq[LANE_X]       <= DVD_W'(prod_x);
		div_out.dq[LANE_Y]       <= DVD_W'(prod_y);
		side_out.xs              <= xs_s3;
		side_out.ys              <= ys_s3;
		side_out.det             <= det_s3;
		side_out.n1              <= n1_s3;
		side_out.n2              <= n2_s3;
		side_out.neg[LANE_U1]    <= n1_s3[WIDE_W-1] ^ det_s3[WIDE_W-1];
		side_out.neg[LANE_U2]    <= n2_s3[WIDE_W-1] ^ det_s3[WIDE_W-1];
		side_out.neg[LANE_X]     <= n1_s3[WIDE_W-1] ^ d12x_s3[DIFF_W-1] ^ det_s3[WIDE_W-1];
		side_out.neg[LANE_Y]     <= n1_s3[WIDE_W-1] ^ d12y_s3[DIFF_W-1] ^ det_s3[WIDE_W-1];
	end

endmodule
`default_nettype wire

// ===== sv/lis_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lis_div_cell: one restoring division step on four lanes
// Develops one quotient bit per lane and hands everything to the next cell.
// ----------------------------------------------------------------------------
module lis_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_in,
	input  lis_pkg::div_t  div_in,
	input  lis_pkg::side_t side_in,
	output logic           valid_out,
	output lis_pkg::div_t  div_out,
	output lis_pkg::side_t side_out
);
	import lis_pkg::*;

	div_t div_d;
	logic [LANES-1:0][REM_W:0] part;
	logic [LANES-1:0][REM_W:0] diff;

	always_comb begin
		div_d = div_in;
		for (int i = 0; i < LANES; i++) begin
			// shift next dividend bit into the partial remainder
			part[i] = {div_in.rem[i], div_in.dq[i][DVD_W-1]};
			diff[i] = part[i] - {1'b0, div_in.dvs};
			if (part[i] >= {1'b0, div_in.dvs}) begin
				div_d.rem[i] = diff[i][REM_W-1:0];
				div_d.dq[i]  = {div_in.dq[i][DVD_W-2:0], 1'b1};
			end else begin
				div_d.rem[i] = part[i][REM_W-1:0];
				div_d.dq[i]  = {div_in.dq[i][DVD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		div_out  <= div_d;
		side_out <= side_in;
	end

endmodule
`default_nettype wire

// ===== sv/lis_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lis_back: parameter saturation, point rounding, clamp and endpoint snap
// Two stages; the second one holds the result registers.
// ----------------------------------------------------------------------------
module lis_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_in,
	input  lis_pkg::div_t                       div_in,
	input  lis_pkg::side_t                      side_in,
	output logic                                done,
	output logic signed [lis_pkg::COORD_W-1:0]  cross_x,
	output logic signed [lis_pkg::COORD_W-1:0]  cross_y,
	output logic signed [lis_pkg::WIDE_W-1:0]   det,
	output logic signed [lis_pkg::WIDE_W-1:0]   num_first,
	output logic signed [lis_pkg::WIDE_W-1:0]   num_second,
	output logic signed [lis_pkg::PARAM_W-1:0]  param_first,
	output logic signed [lis_pkg::PARAM_W-1:0]  param_second,
	output logic                                parallel,
	output logic                                clamped
);
	import lis_pkg::*;

	localparam logic [CMP_W-1:0] POS_LIM = CMP_W'((64'd1 << (PARAM_W - 1)) - 64'd1);
	localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(64'd1 << (PARAM_W - 1));
	localparam logic [PARAM_W-1:0] PARAM_MAX = {1'b0, {(PARAM_W - 1){1'b1}}};
	localparam logic [PARAM_W-1:0] PARAM_MIN = {1'b1, {(PARAM_W - 1){1'b0}}};
	localparam logic signed [SUM_W-1:0] LO = SUM_W'(-(2 ** (COORD_W - 1)));
	localparam logic signed [SUM_W-1:0] HI = SUM_W'((2 ** (COORD_W - 1)) - 1);

	logic [1:0][CMP_W-1:0] qext;
	logic [1:0][PARAM_W-1:0] par_v;
	logic [1:0] inexact, sat, clp, cneg;
	logic signed [SUM_W-1:0] sb [2];
	logic signed [SUM_W-1:0] qq [2];
	logic signed [SUM_W-1:0] sm [2];
	logic [1:0][COORD_W-1:0] cv;
	logic [COORD_W-1:0] base;
	logic is_par;

	logic valid_s1;
	logic [PARAM_W-1:0] u1_s1, u2_s1;
	logic [COORD_W-1:0] cx_s1, cy_s1;
	logic clp_s1, par_s1;
	logic [NPTS-1:0][COORD_W-1:0] xs_s1, ys_s1;
	logic [WIDE_W-1:0] det_s1, n1_s1, n2_s1;

	logic [COORD_W-1:0] sx, sy;
	logic signed [DIFF_W-1:0] dx_t, dy_t;

	logic valid_s2;
	logic [COORD_W-1:0] cx_s2, cy_s2;
	logic [PARAM_W-1:0] u1_s2, u2_s2;
	logic [WIDE_W-1:0] det_s2, n1_s2, n2_s2;
	logic par_s2, clp_s2;

	always_comb begin
		is_par = (side_in.det == '0);
		base   = '0;
		for (int j = 0; j < 2; j++) begin
			// line parameters, saturated in magnitude before the sign
			qext[j] = CMP_W'(div_in.dq[LANE_U1 + j]);
			if (side_in.neg[LANE_U1 + j]) begin
				par_v[j] = (qext[j] > NEG_LIM) ? PARAM_MIN : PARAM_W'(-qext[j]);
			end else begin
				par_v[j] = (qext[j] > POS_LIM) ? PARAM_MAX : PARAM_W'(qext[j]);
			end
			// point coordinate, truncated toward zero
			base       = (j == 0) ? side_in.xs[PT_A] : side_in.ys[PT_A];
			cneg[j]    = side_in.neg[LANE_X + j];
			inexact[j] = |div_in.rem[LANE_X + j];
			sat[j]     = |div_in.dq[LANE_X + j][DVD_W-1:DIFF_W];
			sb[j]      = SUM_W'($signed(base));
			qq[j]      = SUM_W'(div_in.dq[LANE_X + j][DIFF_W-1:0]);
			if (!cneg[j]) begin
				sm[j] = sb[j] + qq[j];
				if (sm[j][SUM_W-1] && inexact[j]) begin
					sm[j] = sm[j] + SUM_W'(1);
				end
			end else begin
				sm[j] = sb[j] - qq[j] - SUM_W'(inexact[j]);
				if (sm[j][SUM_W-1]) begin
					sm[j] = sb[j] - qq[j];
				end
			end
			priority if (sat[j]) begin
				cv[j]  = cneg[j] ? COORD_W'(LO) : COORD_W'(HI);
				clp[j] = 1'b1;
			end else if (sm[j] < LO) begin
				cv[j]  = COORD_W'(LO);
				clp[j] = 1'b1;
			end else if (sm[j] > HI) begin
				cv[j]  = COORD_W'(HI);
				clp[j] = 1'b1;
			end else begin
				cv[j]  = sm[j][COORD_W-1:0];
				clp[j] = 1'b0;
			end
		end
	end

	always_comb begin
		sx = cx_s1;
		sy = cy_s1;
		dx_t = '0;
		dy_t = '0;
		// later endpoints override earlier matches
		for (int i = 0; i < NPTS; i++) begin
			dx_t = DIFF_W'($signed(sx)) - DIFF_W'($signed(xs_s1[i]));
			dy_t = DIFF_W'($signed(sy)) - DIFF_W'($signed(ys_s1[i]));
			if (dx_t >= -1 && dx_t <= 1) begin
				sx = xs_s1[i];
			end
			if (dy_t >= -1 && dy_t <= 1) begin
				sy = ys_s1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		u1_s1  <= is_par ? '0 : par_v[0];
		u2_s1  <= is_par ? '0 : par_v[1];
		cx_s1  <= cv[0];
		cy_s1  <= cv[1];
		clp_s1 <= ~is_par & (clp[0] | clp[1]);
		par_s1 <= is_par;
		xs_s1  <= side_in.xs;
		ys_s1  <= side_in.ys;
		det_s1 <= side_in.det;
		n1_s1  <= side_in.n1;
		n2_s1  <= side_in.n2;

		cx_s2  <= par_s1 ? '0 : sx;
		cy_s2  <= par_s1 ? '0 : sy;
		u1_s2  <= u1_s1;
		u2_s2  <= u2_s1;
		det_s2 <= det_s1;
		n1_s2  <= n1_s1;
		n2_s2  <= n2_s1;
		par_s2 <= par_s1;
		clp_s2 <= clp_s1;
	end

	assign done         = valid_s2;
	assign cross_x      = cx_s2;
	assign cross_y      = cy_s2;
	assign det          = det_s2;
	assign num_first    = n1_s2;
	assign num_second   = n2_s2;
	assign param_first  = u1_s2;
	assign param_second = u2_s2;
	assign parallel     = par_s2;
	assign clamped      = clp_s2;

endmodule
`default_nettype wire

// ===== sv/lis_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lis_checker: port-level checks for line_intersection_snap
// Latency, parallel-case results, determinant consistency and zero-numerator parameters.
// ----------------------------------------------------------------------------
module lis_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic signed [lis_pkg::COORD_W-1:0]  cross_x,
	input logic signed [lis_pkg::COORD_W-1:0]  cross_y,
	input logic signed [lis_pkg::WIDE_W-1:0]   det,
	input logic signed [lis_pkg::WIDE_W-1:0]   num_first,
	input logic signed [lis_pkg::PARAM_W-1:0]  param_first,
	input logic signed [lis_pkg::PARAM_W-1:0]  param_second,
	input logic                                parallel,
	input logic                                clamped
);
	import lis_pkg::*;

	// every result traces back to a start transfer a fixed time earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching transfer");

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && parallel) |-> (cross_x == '0 && cross_y == '0 && param_first == '0
			&& param_second == '0 && !clamped))
		else $error("parallel result not zeroed");

	a_par_det: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (parallel == (det == '0)))
		else $error("parallel flag disagrees with determinant");

	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !parallel && num_first == '0) |-> (param_first == '0))
		else $error("zero numerator gave nonzero parameter");

endmodule

bind line_intersection_snap lis_checker u_lis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.cross_x      (cross_x),
	.cross_y      (cross_y),
	.det          (det),
	.num_first    (num_first),
	.param_first  (param_first),
	.param_second (param_second),
	.parallel     (parallel),
	.clamped      (clamped)
);
`default_nettype wire

// ===== sim/line_intersection_snap_test.sv =====
// ----------------------------------------------------------------------------
// line_intersection_snap_test: self-checking bench for line_intersection_snap
// Drives line pairs through the command port, predicts every result field
// from the endpoints, and compares each done strobe against the oldest
// prediction, with random start gaps in the early phases and none in the last.
// ----------------------------------------------------------------------------
module line_intersection_snap_test;
	import lis_pkg::*;

	localparam int  LIMIT_CYCLES = 200000;
	localparam longint COORD_SAT = 64'sd1 << 40;
	localparam longint PARAM_TOP = 64'sd1 << (PARAM_W - 1);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		coord_t                    px;
		coord_t                    py;
		logic signed [WIDE_W-1:0]  k;
		logic signed [WIDE_W-1:0]  n1;
		logic signed [WIDE_W-1:0]  n2;
		logic signed [PARAM_W-1:0] u1;
		logic signed [PARAM_W-1:0] u2;
		logic                      par;
		logic                      clp;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t a_x = '0, a_y = '0, b_x = '0, b_y = '0;
	coord_t c_x = '0, c_y = '0, d_x = '0, d_y = '0;
	logic done;
	logic signed [COORD_W-1:0] cross_x, cross_y;
	logic signed [WIDE_W-1:0]  det, num_first, num_second;
	logic signed [PARAM_W-1:0] param_first, param_second;
	logic parallel, clamped;

	crossing_t pending_crossings[$];
	int  errors = 0;
	int  cycles = 0;
	bit  gaps_on = 1'b1;

	line_intersection_snap dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
		.c_x(c_x), .c_y(c_y), .d_x(d_x), .d_y(d_y),
		.done(done), .cross_x(cross_x), .cross_y(cross_y),
		.det(det), .num_first(num_first), .num_second(num_second),
		.param_first(param_first), .param_second(param_second),
		.parallel(parallel), .clamped(clamped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t timeout with %0d results outstanding", $time, pending_crossings.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Q.16 quotient, truncated toward zero, saturated to 48 bits
	function automatic longint q16_ratio(longint n, longint k);
		longint q;
		q = (abs64(n) << FRAC_W) / abs64(k);
		if ((n < 0) != (k < 0))
			return q > PARAM_TOP ? -PARAM_TOP : -q;
		return q > PARAM_TOP - 1 ? PARAM_TOP - 1 : q;
	endfunction

	// base + n*dir/k, truncated toward zero of the whole sum
	function automatic longint point_on_line(longint base, longint n, longint dir, longint k);
		longint prod, q, fq, fl, ce, t;
		bit neg, inexact;
		neg = ((n < 0) != (dir < 0)) != (k < 0);
		prod = abs64(n) * abs64(dir);
		q = prod / abs64(k);
		inexact = (prod % abs64(k)) != 0;
		if (q > COORD_SAT) q = COORD_SAT;
		fq = neg ? -q : q;
		fl = fq - ((inexact && neg) ? 1 : 0);
		ce = fq + ((inexact && !neg) ? 1 : 0);
		t = base + fl;
		return t >= 0 ? t : base + ce;
	endfunction

	function automatic longint snap_to_ends(longint v, longint e0, longint e1,
			longint e2, longint e3);
		longint ends[4];
		ends = '{e0, e1, e2, e3};
		foreach (ends[i])
			if (v >= ends[i] - 1 && v <= ends[i] + 1)
				v = ends[i];
		return v;
	endfunction

	function automatic crossing_t predict_crossing(coord_t ax, coord_t ay, coord_t bx,
			coord_t by, coord_t cx, coord_t cy, coord_t dx, coord_t dy);
		crossing_t r;
		longint lax, lay, lbx, lby, lcx, lcy, ldx, ldy;
		longint ux, uy, vx, vy, k, n1, n2, px, py, lo, hi;
		lax = ax; lay = ay; lbx = bx; lby = by;
		lcx = cx; lcy = cy; ldx = dx; ldy = dy;
		ux = lbx - lax; uy = lby - lay; vx = ldx - lcx; vy = ldy - lcy;
		k  = vy * ux - vx * uy;
		n1 = vx * (lay - lcy) - vy * (lax - lcx);
		n2 = ux * (lay - lcy) - uy * (lax - lcx);
		lo = -(64'sd1 << (COORD_W - 1));
		hi = (64'sd1 << (COORD_W - 1)) - 1;
		r.k = k[WIDE_W-1:0];
		r.n1 = n1[WIDE_W-1:0];
		r.n2 = n2[WIDE_W-1:0];
		r.par = (k == 0);
		r.clp = 1'b0;
		r.px = '0; r.py = '0; r.u1 = '0; r.u2 = '0;
		if (!r.par) begin
			r.u1 = PARAM_W'(q16_ratio(n1, k));
			r.u2 = PARAM_W'(q16_ratio(n2, k));
			px = point_on_line(lax, n1, ux, k);
			py = point_on_line(lay, n1, uy, k);
			if (px < lo) begin px = lo; r.clp = 1'b1; end
			if (px > hi) begin px = hi; r.clp = 1'b1; end
			if (py < lo) begin py = lo; r.clp = 1'b1; end
			if (py > hi) begin py = hi; r.clp = 1'b1; end
			px = snap_to_ends(px, lax, lbx, lcx, ldx);
			py = snap_to_ends(py, lay, lby, lcy, ldy);
			r.px = px[COORD_W-1:0];
			r.py = py[COORD_W-1:0];
		end
		return r;
	endfunction

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// checks each result on its strobe cycle
	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && done) begin
			if (pending_crossings.size() == 0) begin
				errors++;
				$display("%0t result with nothing expected", $time);
			end else begin
				e = pending_crossings.pop_front();
				compare_field("cross_x", 64'(e.px), 64'(cross_x));
				compare_field("cross_y", 64'(e.py), 64'(cross_y));
				compare_field("det", 64'(e.k), 64'(det));
				compare_field("num_first", 64'(e.n1), 64'(num_first));
				compare_field("num_second", 64'(e.n2), 64'(num_second));
				compare_field("param_first", 64'(e.u1), 64'(param_first));
				compare_field("param_second", 64'(e.u2), 64'(param_second));
				compare_field("parallel", 64'(e.par), 64'(parallel));
				compare_field("clamped", 64'(e.clp), 64'(clamped));
			end
		end
	end

	task automatic send_lines(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy, coord_t dx, coord_t dy);
		int gap;
		a_x <= ax; a_y <= ay; b_x <= bx; b_y <= by;
		c_x <= cx; c_y <= cy; d_x <= dx; d_y <= dy;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_crossings.push_back(predict_crossing(ax, ay, bx, by, cx, cy, dx, dy));
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic coord_t rnd_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t near(coord_t v, int span);
		return coord_t'(int'(v) + $urandom_range(0, 2 * span) - span);
	endfunction

	task automatic test_directed();
		send_lines(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_lines(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
		// parallel and degenerate lines
		send_lines(0, 0, 10, 10, 0, 5, 10, 15);
		send_lines(0, 0, 0, 0, 3, 4, 5, 6);
		send_lines(7, 7, 7, 7, 7, 7, 7, 7);
		send_lines(-32768, 0, 32767, 0, -32768, 1, 32767, 1);
		// intersection at an endpoint and next to one
		send_lines(0, 0, 10, 0, 5, -5, 5, 5);
		send_lines(0, 0, 10, 10, 0, 10, 10, 0);
		send_lines(0, 0, 3, 1, 1, 0, 0, 3);
		send_lines(-5, -5, 5, 6, -5, 6, 5, -5);
		// far-away crossing forces clamping and parameter saturation
		send_lines(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767);
		send_lines(32767, -32768, -32768, 32766, 32767, -32767, -32768, 32767);
		send_lines(0, 0, 1, 0, 0, 1, 32767, 2);
		send_lines(0, 0, 1, 0, 0, -1, -32768, -2);
		send_lines(-32768, -32768, -32767, -32768, 32767, 32767, 32767, 32766);
		send_lines(1, 1, 2, 2, 3, 3, 5, 4);
		send_lines(-1, -1, -2, -2, -3, -3, -5, -4);
	endtask

	task automatic test_random_lines(int count);
		repeat (count)
			send_lines(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
				rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
	endtask

	// small coordinates put the crossing within snapping distance often
	task automatic test_snap_region(int count);
		repeat (count)
			send_lines(coord_t'($urandom_range(0, 12) - 6), coord_t'($urandom_range(0, 12) - 6),
				coord_t'($urandom_range(0, 12) - 6), coord_t'($urandom_range(0, 12) - 6),
				coord_t'($urandom_range(0, 12) - 6), coord_t'($urandom_range(0, 12) - 6),
				coord_t'($urandom_range(0, 12) - 6), coord_t'($urandom_range(0, 12) - 6));
	endtask

	// nearly parallel pairs: huge parameters, clamped points, exact parallels
	task automatic test_near_parallel(int count);
		coord_t ax, ay, bx, by, cx, cy;
		repeat (count) begin
			ax = rnd_coord(); ay = rnd_coord(); bx = rnd_coord(); by = rnd_coord();
			cx = near(ax, 40); cy = near(ay, 40);
			send_lines(ax, ay, bx, by, cx, cy,
				coord_t'(int'(cx) + int'(bx) - int'(ax) + $urandom_range(0, 2) - 1),
				coord_t'(int'(cy) + int'(by) - int'(ay) + $urandom_range(0, 2) - 1));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_lines(150);
		test_snap_region(110);
		test_near_parallel(110);
		gaps_on = 1'b0;
		test_random_lines(40);
		test_near_parallel(40);
		start <= 1'b0;
		while (pending_crossings.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/lis_pkg.sv
sv/lis_front.sv
sv/lis_div_cell.sv
sv/lis_back.sv
sv/line_intersection_snap.sv
sv/lis_checker.sv
sim/line_intersection_snap_test.sv
